// ===== src/mssd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mssd_pkg
// Shared types, constants and the channel-to-switch map of the multiplexed
// switch scanner.
// ----------------------------------------------------------------------------
package mssd_pkg;

   localparam int NUM_SWITCHES = 10;
   localparam int MUX_CHANNELS = 8;
   localparam int CHAN_W       = $clog2(MUX_CHANNELS);
   localparam int SW_IDX_W     = $clog2(NUM_SWITCHES);
   localparam int TICK_W       = 16;
   localparam int DEB_W        = 8;
   localparam int CSR_DATA_W   = 16;

   localparam logic [TICK_W-1:0] TICK_MAX = 16'hFFFF;

   localparam logic CSR_SCAN_PERIOD    = 1'b0;
   localparam logic CSR_DEBOUNCE_COUNT = 1'b1;

   localparam logic [TICK_W-1:0] SCAN_PERIOD_RESET    = 16'd5;
   localparam logic [DEB_W-1:0]  DEBOUNCE_COUNT_RESET = 8'd3;

   typedef struct packed {
      logic                used;
      logic [SW_IDX_W-1:0] sw;
   } map_entry_type;

   typedef map_entry_type [MUX_CHANNELS-1:0] map_table_type;

   localparam map_entry_type NO_SW = '{used: 1'b0, sw: 4'd0};

   localparam map_table_type LINE1_MAP = '{
      7: NO_SW,
      6: '{used: 1'b1, sw: 4'd4},
      5: NO_SW,
      4: '{used: 1'b1, sw: 4'd3},
      3: '{used: 1'b1, sw: 4'd0},
      2: '{used: 1'b1, sw: 4'd2},
      1: NO_SW,
      0: '{used: 1'b1, sw: 4'd1}
   };

   localparam map_table_type LINE2_MAP = '{
      7: '{used: 1'b1, sw: 4'd8},
      6: '{used: 1'b1, sw: 4'd7},
      5: '{used: 1'b1, sw: 4'd9},
      4: '{used: 1'b1, sw: 4'd6},
      3: NO_SW,
      2: NO_SW,
      1: NO_SW,
      0: '{used: 1'b1, sw: 4'd5}
   };

   typedef struct packed {
      logic              request;
      logic              read_strobe;
      logic              released;
      logic              held_in;
      logic [CHAN_W-1:0] select_in;
      logic [CHAN_W-1:0] channel;
      logic              settling;
   } scan_status_type;

   function automatic logic [NUM_SWITCHES-1:0] line_mask(input map_entry_type entry);
      logic [NUM_SWITCHES-1:0] mask;
      mask = '0;
      if (entry.used) begin
         mask = NUM_SWITCHES'(1) << entry.sw;
      end
      return mask;
   endfunction

endpackage

// ===== src/muxed_switch_scan_debounce.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// muxed_switch_scan_debounce
// Multiplexed switch scanner with counter debounce on ten switches.
//
//   Channel  Direction  Handshake             Payload
//   req      in         req_valid/req_ready   k1_level, k2_level, mux_granted
//   rsp      out        rsp_valid/rsp_ready   mux_request, mux_select, mux_held,
//                                             mux_released, raw_bits, stable_bits
//   csr      in         csr_write             csr_index, csr_wdata
//
// One tick transfer per cycle while the result is not stalled; the result appears
// in the result register in the cycle after the transfer. The only loop is state
// update through the tick counter and debounce cells. Reset clears the scan and
// debounce state to open, clears rsp_valid and loads the register defaults. A
// stalled result holds the result register; req_ready then drops until it transfers.
// ----------------------------------------------------------------------------
module muxed_switch_scan_debounce (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_k1_level,
   input  logic                                req_k2_level,
   input  logic                                req_mux_granted,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_mux_request,
   output logic [mssd_pkg::CHAN_W-1:0]         rsp_mux_select,
   output logic                                rsp_mux_held,
   output logic                                rsp_mux_released,
   output logic [mssd_pkg::NUM_SWITCHES-1:0]   rsp_raw_bits,
   output logic [mssd_pkg::NUM_SWITCHES-1:0]   rsp_stable_bits,
   input  logic                                csr_write,
   input  logic                                csr_index,
   input  logic [mssd_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import mssd_pkg::*;

   logic [TICK_W-1:0]       scan_period_ff;
   logic [DEB_W-1:0]        debounce_ff;
   logic                    accept;
   scan_status_type         status;
   logic [NUM_SWITCHES-1:0] mask1, mask2, raw_in, stable_in;

   logic                    rsp_valid_ff, request_ff, held_ff, released_ff;
   logic [CHAN_W-1:0]       select_ff;
   logic [NUM_SWITCHES-1:0] raw_ff, stable_ff;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_period_ff <= SCAN_PERIOD_RESET;
         debounce_ff    <= DEBOUNCE_COUNT_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_SCAN_PERIOD:    scan_period_ff <= csr_wdata;
            CSR_DEBOUNCE_COUNT: debounce_ff    <= csr_wdata[DEB_W-1:0];
         endcase
      end
   end

   mssd_scan_ctrl u_scan (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .mux_granted (req_mux_granted),
      .scan_period (scan_period_ff),
      .status      (status)
   );

   assign mask1 = line_mask(LINE1_MAP[status.channel]);
   assign mask2 = line_mask(LINE2_MAP[status.channel]);

   for (genvar i = 0; i < NUM_SWITCHES; i++) begin : g_cell
      mssd_debounce_cell u_cell (
         .clock          (clock),
         .reset          (reset),
         .update         (accept && status.read_strobe && (mask1[i] || mask2[i])),
         .level          (mask1[i] ? req_k1_level : req_k2_level),
         .debounce_count (debounce_ff),
         .raw_in         (raw_in[i]),
         .stable_in      (stable_in[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         request_ff  <= status.request;
         select_ff   <= status.select_in;
         held_ff     <= status.held_in;
         released_ff <= status.released;
         raw_ff      <= raw_in;
         stable_ff   <= stable_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_mux_request  = request_ff;
   assign rsp_mux_select   = select_ff;
   assign rsp_mux_held     = held_ff;
   assign rsp_mux_released = released_ff;
   assign rsp_raw_bits     = raw_ff;
   assign rsp_stable_bits  = stable_ff;

`ifndef SYNTHESIS
   a_release_shown: assert property (@(posedge clock) disable iff (reset)
      accept && status.released |=> rsp_valid && rsp_mux_released && !rsp_mux_held)
      else $error("release not shown in result");

   a_channel_advance: assert property (@(posedge clock) disable iff (reset)
      accept && status.released |=> status.channel == $past(status.channel) + CHAN_W'(1))
      else $error("channel did not advance after read");

   a_no_grant_hold: assert property (@(posedge clock) disable iff (reset)
      accept && !(status.request && req_mux_granted)
      |=> $stable(status.channel) && $stable(status.settling))
      else $error("phase changed without grant");

   a_select_phase: assert property (@(posedge clock) disable iff (reset)
      accept && status.request && req_mux_granted && !status.settling
      |=> status.settling && rsp_mux_held)
      else $error("select phase did not mark settling");
`endif

endmodule

// ===== src/mssd_scan_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mssd_scan_ctrl
// Tick counter, mux request and grant handling, select/read phase and
// channel advance.
// ----------------------------------------------------------------------------
module mssd_scan_ctrl (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            accept,
   input  logic                            mux_granted,
   input  logic [mssd_pkg::TICK_W-1:0]     scan_period,
   output mssd_pkg::scan_status_type       status
);
   import mssd_pkg::*;

   logic [TICK_W-1:0] tick_ff, tick_in, tick_inc;
   logic [CHAN_W-1:0] channel_ff, channel_in;
   logic              settling_ff, settling_in;
   logic              request, grant;

   always_comb begin
      tick_inc    = (tick_ff != TICK_MAX) ? tick_ff + TICK_W'(1) : tick_ff;
      request     = (tick_inc >= scan_period);
      grant       = request && mux_granted;
      tick_in     = grant ? '0 : tick_inc;
      channel_in  = channel_ff;
      settling_in = settling_ff;
      if (grant) begin
         if (settling_ff) begin
            channel_in  = channel_ff + CHAN_W'(1);
            settling_in = 1'b0;
         end else begin
            settling_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff     <= '0;
         channel_ff  <= '0;
         settling_ff <= 1'b0;
      end else if (accept) begin
         tick_ff     <= tick_in;
         channel_ff  <= channel_in;
         settling_ff <= settling_in;
      end
   end

   assign status.request     = request;
   assign status.read_strobe = grant && settling_ff;
   assign status.released    = grant && settling_ff;
   assign status.held_in     = settling_in;
   assign status.select_in   = channel_in;
   assign status.channel     = channel_ff;
   assign status.settling    = settling_ff;

endmodule

// ===== src/mssd_debounce_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mssd_debounce_cell
// Counter debounce for one switch: raw sample, candidate level, match count
// and stable level.
// ----------------------------------------------------------------------------
module mssd_debounce_cell (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         update,
   input  logic                         level,
   input  logic [mssd_pkg::DEB_W-1:0]   debounce_count,
   output logic                         raw_in,
   output logic                         stable_in
);
   import mssd_pkg::*;

   logic             raw_ff, stable_ff, cand_ff, cand_in;
   logic [DEB_W-1:0] match_ff, match_in, match_step;
   logic             stable_step;

   always_comb begin
      if (cand_ff == level) begin
         match_step = (match_ff < debounce_count) ? match_ff + DEB_W'(1) : match_ff;
      end else begin
         match_step = DEB_W'(1);
      end
      stable_step = (match_step >= debounce_count) ? level : stable_ff;
      raw_in      = update ? level       : raw_ff;
      cand_in     = update ? level       : cand_ff;
      match_in    = update ? match_step  : match_ff;
      stable_in   = update ? stable_step : stable_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_ff    <= 1'b0;
         stable_ff <= 1'b0;
         cand_ff   <= 1'b0;
         match_ff  <= '0;
      end else begin
         raw_ff    <= raw_in;
         stable_ff <= stable_in;
         cand_ff   <= cand_in;
         match_ff  <= match_in;
      end
   end

endmodule

// ===== dv/tb_muxed_switch_scan_debounce.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_muxed_switch_scan_debounce
// Self-checking bench for the multiplexed switch scanner. A queue of tick
// transfers feeds a driver, and a monitor predicts each result at the moment
// of the input transfer and compares it with the result transfer, field by
// field. Runs cover the reset settings, a full sweep of the channels, the
// longest scan period, the largest and smallest debounce counts, and random
// phases of slowly changing switch levels with noise and random grants.
// ----------------------------------------------------------------------------
module tb_muxed_switch_scan_debounce;
   import mssd_pkg::*;

   localparam int IDLE_PCT       = 19;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int UNMAPPED       = -1;

   typedef struct packed {
      logic k1;
      logic k2;
      logic grant;
   } tick_item_t;

   typedef struct packed {
      logic                    request;
      logic [CHAN_W-1:0]       select;
      logic                    held;
      logic                    released;
      logic [NUM_SWITCHES-1:0] raw;
      logic [NUM_SWITCHES-1:0] stable;
   } scan_result_t;

   logic                    clock           = 1'b0;
   logic                    reset           = 1'b1;
   logic                    req_valid       = 1'b0;
   logic                    req_ready;
   logic                    req_k1_level    = 1'b0;
   logic                    req_k2_level    = 1'b0;
   logic                    req_mux_granted = 1'b0;
   logic                    rsp_valid;
   logic                    rsp_ready       = 1'b0;
   logic                    rsp_mux_request;
   logic [CHAN_W-1:0]       rsp_mux_select;
   logic                    rsp_mux_held;
   logic                    rsp_mux_released;
   logic [NUM_SWITCHES-1:0] rsp_raw_bits;
   logic [NUM_SWITCHES-1:0] rsp_stable_bits;
   logic                    csr_write       = 1'b0;
   logic                    csr_index       = CSR_SCAN_PERIOD;
   logic [CSR_DATA_W-1:0]   csr_wdata       = '0;

   tick_item_t   tick_q[$];
   scan_result_t scan_expect_q[$];
   logic         req_taken = 1'b0;
   bit           quiet = 1'b0;
   int           idle_cycles = 0;
   int           err_count = 0;
   int           ticks_sent = 0;
   int           results_checked = 0;
   int           reads_seen = 0;
   int           settings_count = 0;

   // scanner state as predicted
   logic [TICK_W-1:0]       period_cfg   = SCAN_PERIOD_RESET;
   logic [DEB_W-1:0]        debounce_cfg = DEBOUNCE_COUNT_RESET;
   logic [TICK_W-1:0]       tick_cnt     = '0;
   logic [CHAN_W-1:0]       scan_chan    = '0;
   logic                    settling     = 1'b0;
   logic [NUM_SWITCHES-1:0] raw_sw       = '0;
   logic [NUM_SWITCHES-1:0] stable_sw    = '0;
   logic [NUM_SWITCHES-1:0] cand_sw      = '0;
   logic [DEB_W-1:0]        match_cnt [NUM_SWITCHES];

   muxed_switch_scan_debounce dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_k1_level     (req_k1_level),
      .req_k2_level     (req_k2_level),
      .req_mux_granted  (req_mux_granted),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_mux_request  (rsp_mux_request),
      .rsp_mux_select   (rsp_mux_select),
      .rsp_mux_held     (rsp_mux_held),
      .rsp_mux_released (rsp_mux_released),
      .rsp_raw_bits     (rsp_raw_bits),
      .rsp_stable_bits  (rsp_stable_bits),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic int mapped_switch(input logic line2, input logic [CHAN_W-1:0] ch);
      int sw;
      sw = UNMAPPED;
      if (!line2) begin
         case (ch)
            3'd0: sw = 1;
            3'd2: sw = 2;
            3'd3: sw = 0;
            3'd4: sw = 3;
            3'd6: sw = 4;
            default: sw = UNMAPPED;
         endcase
      end else begin
         case (ch)
            3'd0: sw = 5;
            3'd4: sw = 6;
            3'd5: sw = 9;
            3'd6: sw = 7;
            3'd7: sw = 8;
            default: sw = UNMAPPED;
         endcase
      end
      return sw;
   endfunction

   function automatic void debounce_sample(input int sw, input logic level);
      if (sw == UNMAPPED) begin
         return;
      end
      raw_sw[sw] = level;
      if (cand_sw[sw] == level) begin
         if (match_cnt[sw] < debounce_cfg) begin
            match_cnt[sw] = match_cnt[sw] + 1'b1;
         end
      end else begin
         cand_sw[sw]   = level;
         match_cnt[sw] = 8'd1;
      end
      if (match_cnt[sw] >= debounce_cfg) begin
         stable_sw[sw] = level;
      end
   endfunction

   function automatic scan_result_t advance_scanner(input tick_item_t t);
      scan_result_t r;
      r = '0;
      if (tick_cnt != TICK_MAX) begin
         tick_cnt = tick_cnt + 1'b1;
      end
      if (tick_cnt >= period_cfg) begin
         r.request = 1'b1;
         if (t.grant) begin
            tick_cnt = '0;
            if (settling) begin
               debounce_sample(mapped_switch(1'b0, scan_chan), t.k1);
               debounce_sample(mapped_switch(1'b1, scan_chan), t.k2);
               scan_chan  = scan_chan + 1'b1;
               settling   = 1'b0;
               r.released = 1'b1;
            end else begin
               settling = 1'b1;
            end
         end
      end
      r.select = scan_chan;
      r.held   = settling;
      r.raw    = raw_sw;
      r.stable = stable_sw;
      return r;
   endfunction

   function automatic void check_field(input string name, input logic [15:0] want,
                                       input logic [15:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         err_count++;
      end
   endfunction

   // driver: hold payload until transfer, then advance
   always @(negedge clock) begin : tick_driver
      tick_item_t nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (tick_q.size() != 0 && (quiet || $urandom_range(99) >= IDLE_PCT)) begin
            nxt = tick_q.pop_front();
            req_valid       <= 1'b1;
            req_k1_level    <= nxt.k1;
            req_k2_level    <= nxt.k2;
            req_mux_granted <= nxt.grant;
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
   end

   // monitor: predict on tick transfer, compare on result transfer
   always @(posedge clock) begin : result_check
      scan_result_t got;
      scan_result_t want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && req_ready;
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_mux_request, rsp_mux_select, rsp_mux_held, rsp_mux_released,
                    rsp_raw_bits, rsp_stable_bits};
            results_checked++;
            if (got.released === 1'b1) begin
               reads_seen++;
            end
            if (scan_expect_q.size() == 0) begin
               $error("result transfer with no tick outstanding");
               err_count++;
            end else begin
               want = scan_expect_q.pop_front();
               check_field("mux_request", 16'(want.request), 16'(got.request));
               check_field("mux_select", 16'(want.select), 16'(got.select));
               check_field("mux_held", 16'(want.held), 16'(got.held));
               check_field("mux_released", 16'(want.released), 16'(got.released));
               check_field("raw_bits", 16'(want.raw), 16'(got.raw));
               check_field("stable_bits", 16'(want.stable), 16'(got.stable));
            end
         end
         if (req_valid && req_ready) begin
            scan_expect_q.push_back(advance_scanner('{req_k1_level, req_k2_level,
                                                      req_mux_granted}));
            ticks_sent++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic wait_idle();
      do @(negedge clock);
      while (tick_q.size() != 0 || req_valid || scan_expect_q.size() != 0);
      repeat (2) @(negedge clock);
   endtask

   task automatic apply_setting(input logic [TICK_W-1:0] period,
                                input logic [DEB_W-1:0] thresh);
      wait_idle();
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= CSR_SCAN_PERIOD;
      csr_wdata <= period;
      @(negedge clock);
      csr_index <= CSR_DEBOUNCE_COUNT;
      csr_wdata <= CSR_DATA_W'(thresh);
      @(negedge clock);
      csr_write <= 1'b0;
      period_cfg   = period;
      debounce_cfg = thresh;
      settings_count++;
   endtask

   initial begin : stimulus
      tick_item_t it;
      logic       k1_line;
      logic       k2_line;
      int         flip_pm;
      int         n;
      foreach (match_cnt[i]) begin
         match_cnt[i] = '0;
      end
      k1_line = 1'b0;
      k2_line = 1'b0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // reset settings: grant ignored below period, request left waiting, select
      for (n = 0; n < 9; n++) begin
         tick_q.push_back('{n[0], n[1], (n != 4)});
      end

      // request every tick, read all eight channels with both lines closed
      apply_setting(16'd0, 8'd1);
      for (n = 0; n < 16; n++) begin
         tick_q.push_back('{1'b1, 1'b1, 1'b1});
      end

      // longest period: grants ignored while counting
      apply_setting(TICK_MAX, 8'd2);
      for (n = 0; n < 100; n++) begin
         it.k1    = 1'($urandom_range(1));
         it.k2    = 1'($urandom_range(1));
         it.grant = 1'($urandom_range(1));
         tick_q.push_back(it);
      end

      // largest debounce count: stable state holds through a run of open samples
      apply_setting(16'd0, 8'd255);
      for (n = 0; n < 100; n++) begin
         tick_q.push_back('{1'b0, 1'b0, 1'b1});
      end

      for (int p = 0; p < 9; p++) begin
         case (p)
            0: apply_setting(16'd0, 8'd0);
            1: apply_setting(16'd1, 8'd1);
            2: apply_setting(16'd0, 8'd3);
            3: apply_setting(16'd0, 8'd2);
            4: apply_setting(16'd1, 8'd4);
            5: apply_setting(SCAN_PERIOD_RESET, DEBOUNCE_COUNT_RESET);
            default: apply_setting(16'($urandom_range(3)), 8'($urandom_range(1, 6)));
         endcase
         quiet = (p == 3);
         flip_pm = 26 / ((int'(period_cfg) + 1) * ((debounce_cfg == 0) ? 1 : int'(debounce_cfg)));
         if (flip_pm == 0) begin
            flip_pm = 1;
         end
         for (n = 0; n < 190; n++) begin
            if ($urandom_range(99) < 5) begin
               it.k1 = 1'($urandom_range(1));
               it.k2 = 1'($urandom_range(1));
            end else begin
               if ($urandom_range(999) < flip_pm) begin
                  k1_line = ~k1_line;
               end
               if ($urandom_range(999) < flip_pm) begin
                  k2_line = ~k2_line;
               end
               it.k1 = k1_line;
               it.k2 = k2_line;
            end
            it.grant = ($urandom_range(99) < 85);
            tick_q.push_back(it);
         end
      end

      wait_idle();
      quiet = 1'b0;
      repeat (4) @(negedge clock);
      $display("Checked %0d results from %0d tick transfers, %0d of them switch reads,",
               results_checked, ticks_sent, reads_seen);
      $display("across %0d register settings incl. period 0 and 65535, debounce 0 and 255",
               settings_count);
      if (err_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
src/mssd_pkg.sv
src/mssd_scan_ctrl.sv
src/mssd_debounce_cell.sv
src/muxed_switch_scan_debounce.sv
dv/tb_muxed_switch_scan_debounce.sv
